FILE: rtl/mbd_pkg.sv
// Package for the masked box decimator: sizes, payload structs and register indexes.
// No dependencies.
package mbd_pkg;

  localparam int MaxOutWidth  = 1024;
  localparam int MaxRatio     = 16;
  localparam int MaxChannels  = 4;
  localparam int SampleBits   = 16;
  localparam int ColBits      = $clog2(MaxOutWidth);
  localparam int RatioBits    = $clog2(MaxRatio);
  localparam int SumBits      = SampleBits + 2 * RatioBits;
  localparam int CntBits      = 2 * RatioBits + 1;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 11;

  localparam logic [CfgIdxBits-1:0] RegRatioX   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRatioY   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegOutWidth = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegChannels = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegMaskEn   = 3'd4;

  typedef struct packed {
    logic [SampleBits-1:0] sample_3;
    logic [SampleBits-1:0] sample_2;
    logic [SampleBits-1:0] sample_1;
    logic [SampleBits-1:0] sample_0;
    logic                  pixel_valid;
  } pix_in_t;

  typedef struct packed {
    logic [SampleBits-1:0] avg_3;
    logic [SampleBits-1:0] avg_2;
    logic [SampleBits-1:0] avg_1;
    logic [SampleBits-1:0] avg_0;
    logic                  used_fallback;
    logic                  line_end;
  } pix_out_t;

endpackage

FILE: rtl/masked_box_decimator_core.sv
// Masked box decimator top level: column state memory, read-modify-write and a
// shared serial divider. Depends on mbd_pkg.
// A pixel that closes no block is accepted, read from the column memory, then updated
// and written back. A block's last pixel then runs the serial division and an output
// step per active channel and loads the output register, which may wait on out_ready.
// No new pixel is taken until the current one is through. Reset restores the state,
// config, counters and out_valid; column memories and data registers are not cleared.
module masked_box_decimator_core
  import mbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pix_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pix_out_t               out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  typedef enum logic [2:0] {StIdle, StRead, StUpd, StDiv, StOut, StPush} state_e;
  localparam int MemW = MaxChannels * SumBits + CntBits + MaxChannels * SampleBits;
  localparam int DivCntBits = $clog2(SumBits + 1);

  state_e state_q;
  logic [4:0]  ratio_x_q, ratio_y_q;
  logic [10:0] out_width_q;
  logic [2:0]  chan_q;
  logic        mask_en_q;
  logic [ColBits-1:0]   col_q;
  logic [RatioBits-1:0] sub_q, row_q;
  pix_in_t pix_q;
  logic [MemW-1:0] mem [MaxOutWidth];
  logic [MemW-1:0] rd_q;
  logic [MaxChannels*SumBits-1:0] sums_q;
  logic [CntBits-1:0] cnt_q;
  logic [MaxChannels*SampleBits-1:0] first_q;
  logic lend_q;
  logic [1:0] dch_q;
  logic [DivCntBits-1:0] dstep_q;
  logic [SumBits-1:0] quo_q;
  logic [CntBits:0] rem_q;
  pix_out_t res_q;
  pix_out_t out_q;
  logic out_valid_q;
  logic push;

  logic [RatioBits:0] rx, ry;
  logic [ColBits:0] ow;
  logic [2:0] nc;
  always_comb begin
    rx = (ratio_x_q == 5'd0) ? (RatioBits+1)'(1) :
         (ratio_x_q > 5'(MaxRatio)) ? (RatioBits+1)'(MaxRatio) : (RatioBits+1)'(ratio_x_q);
    ry = (ratio_y_q == 5'd0) ? (RatioBits+1)'(1) :
         (ratio_y_q > 5'(MaxRatio)) ? (RatioBits+1)'(MaxRatio) : (RatioBits+1)'(ratio_y_q);
    ow = (out_width_q == 11'd0) ? (ColBits+1)'(1) :
         (out_width_q > 11'(MaxOutWidth)) ? (ColBits+1)'(MaxOutWidth)
                                           : (ColBits+1)'(out_width_q);
    nc = (chan_q == 3'd0) ? 3'd1 : (chan_q > 3'(MaxChannels)) ? 3'(MaxChannels) : chan_q;
  end

  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign push        = (state_q == StPush) && (!out_valid_q || out_ready_i);

  logic first_px, valid_px, is_last;
  logic [MaxChannels*SumBits-1:0] sums_new;
  logic [CntBits-1:0] cnt_new;
  logic [MaxChannels*SampleBits-1:0] first_new;
  logic [SampleBits-1:0] smp [MaxChannels];
  always_comb begin
    smp[0] = pix_q.sample_0; smp[1] = pix_q.sample_1;
    smp[2] = pix_q.sample_2; smp[3] = pix_q.sample_3;
    first_px = (row_q == '0) && (sub_q == '0);
    valid_px = !mask_en_q || pix_q.pixel_valid;
    is_last  = ({1'b0, row_q} == ry - 1'b1) && ({1'b0, sub_q} == rx - 1'b1);
    cnt_new  = (first_px ? '0 : rd_q[MaxChannels*SampleBits +: CntBits]) +
               CntBits'(valid_px);
    first_new = first_px ? {smp[3], smp[2], smp[1], smp[0]}
                         : rd_q[0 +: MaxChannels*SampleBits];
    for (int c = 0; c < MaxChannels; c++) begin
      sums_new[c*SumBits +: SumBits] =
        (first_px ? '0 : rd_q[MaxChannels*SampleBits+CntBits+c*SumBits +: SumBits]) +
        ((valid_px && (3'(c) < nc)) ? SumBits'(smp[c]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRead) rd_q <= mem[col_q];
    if (state_q == StUpd) mem[col_q] <= {sums_new, cnt_new, first_new};
  end

  logic [CntBits:0] rem_sh;
  logic [SumBits-1:0] cur_sum;
  always_comb begin
    cur_sum = sums_q[dch_q*SumBits +: SumBits];
    rem_sh  = {rem_q[CntBits-1:0], cur_sum[SumBits-1 - 5'(dstep_q)]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ratio_x_q <= 5'd1; ratio_y_q <= 5'd1; out_width_q <= 11'd1;
      chan_q <= 3'd1; mask_en_q <= 1'b0;
      col_q <= '0; sub_q <= '0; row_q <= '0;
      out_valid_q <= 1'b0;
      dch_q <= '0; dstep_q <= '0;
    end else begin
      if (push) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cfg_valid_i) begin
            if (cfg_index_i <= RegMaskEn) begin
              col_q <= '0; sub_q <= '0; row_q <= '0;
            end
            case (cfg_index_i)
              RegRatioX:   ratio_x_q <= cfg_data_i[4:0];
              RegRatioY:   ratio_y_q <= cfg_data_i[4:0];
              RegOutWidth: out_width_q <= cfg_data_i;
              RegChannels: chan_q <= cfg_data_i[2:0];
              RegMaskEn:   mask_en_q <= cfg_data_i[0];
              default: ;
            endcase
          end else if (in_valid_i && in_ready_o) begin
            pix_q <= in_data_i;
            if ({1'b0, col_q} >= ow) col_q <= '0;
            if ({1'b0, sub_q} >= rx) sub_q <= '0;
            if ({1'b0, row_q} >= ry) row_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StUpd;
        StUpd: begin
          sums_q <= sums_new; cnt_q <= cnt_new; first_q <= first_new;
          lend_q <= ({1'b0, col_q} == ow - 1'b1);
          dch_q <= '0; dstep_q <= '0; rem_q <= '0;
          res_q <= '0;
          if ({1'b0, sub_q} + 1'b1 >= rx) begin
            sub_q <= '0;
            if ({1'b0, col_q} + 1'b1 >= ow) begin
              col_q <= '0;
              row_q <= ({1'b0, row_q} + 1'b1 >= ry) ? '0 : row_q + 1'b1;
            end else col_q <= col_q + 1'b1;
          end else sub_q <= sub_q + 1'b1;
          state_q <= is_last ? StDiv : StIdle;
        end
        StDiv: begin
          if (rem_sh >= {1'b0, cnt_q}) begin
            rem_q <= rem_sh - {1'b0, cnt_q};
            quo_q <= {quo_q[SumBits-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[SumBits-2:0], 1'b0};
          end
          dstep_q <= dstep_q + 1'b1;
          if (dstep_q == DivCntBits'(SumBits - 1)) state_q <= StOut;
        end
        StOut: begin
          unique case (dch_q)
            2'd0: res_q.avg_0 <= (cnt_q == '0) ? first_q[0 +: SampleBits]
                                               : quo_q[SampleBits-1:0];
            2'd1: res_q.avg_1 <= (cnt_q == '0) ? first_q[SampleBits +: SampleBits]
                                               : quo_q[SampleBits-1:0];
            2'd2: res_q.avg_2 <= (cnt_q == '0) ? first_q[2*SampleBits +: SampleBits]
                                               : quo_q[SampleBits-1:0];
            default: res_q.avg_3 <= (cnt_q == '0) ? first_q[3*SampleBits +: SampleBits]
                                                  : quo_q[SampleBits-1:0];
          endcase
          dstep_q <= '0; rem_q <= '0;
          if (3'(dch_q) + 3'd1 >= nc) begin
            res_q.used_fallback <= (cnt_q == '0);
            res_q.line_end <= lend_q;
            state_q <= StPush;
          end else begin
            dch_q <= dch_q + 1'b1;
            state_q <= StDiv;
          end
        end
        StPush: begin
          if (push) begin
            out_q <= res_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |=> (state_q == StUpd)) else $error("read not followed by update");
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StPush)) else $error("stray result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("result changed while waiting");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for masked_box_decimator_core: drives source pixels and
// register writes, predicts every output pixel and compares it. Depends on mbd_pkg.
`timescale 1ns / 100ps

module tb;
  import mbd_pkg::*;

  localparam int SettleCycles = 120;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  pix_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  pix_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  // Register images and the block state as the decimator should hold them.
  int unsigned reg_ratio_x, reg_ratio_y, reg_out_width, reg_channels, reg_mask_en;
  int unsigned col_sum [MaxOutWidth][MaxChannels];
  int unsigned col_cnt [MaxOutWidth];
  logic [SampleBits-1:0] col_first [MaxOutWidth][MaxChannels];
  int unsigned pos_col, pos_sub, pos_row;

  pix_out_t    pending_pixels[$];
  int unsigned errors;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned fallbacks_seen;
  bit          quiet_stretch;
  int unsigned hold_cycles;

  masked_box_decimator_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SampleBits-1:0] sample_of(pix_in_t p, int ch);
    case (ch)
      0: return p.sample_0;
      1: return p.sample_1;
      2: return p.sample_2;
      default: return p.sample_3;
    endcase
  endfunction

  function automatic void apply_register(logic [CfgIdxBits-1:0] idx,
                                         logic [CfgDataBits-1:0] val);
    case (idx)
      RegRatioX:   reg_ratio_x = val & 5'h1f;
      RegRatioY:   reg_ratio_y = val & 5'h1f;
      RegOutWidth: reg_out_width = val;
      RegChannels: reg_channels = val & 3'h7;
      RegMaskEn:   reg_mask_en = val & 1'b1;
      default:     return;
    endcase
    pos_col = 0;
    pos_sub = 0;
    pos_row = 0;
  endfunction

  // Accumulates one source pixel and queues the output pixel when it closes a block.
  function automatic void decimate_pixel(pix_in_t p);
    int unsigned rx, ry, ow, nc, cnt, v;
    logic [SampleBits-1:0] avg [MaxChannels];
    pix_out_t res;
    rx = clamp(reg_ratio_x, 1, MaxRatio);
    ry = clamp(reg_ratio_y, 1, MaxRatio);
    ow = clamp(reg_out_width, 1, MaxOutWidth);
    nc = clamp(reg_channels, 1, MaxChannels);
    if (pos_col >= ow) pos_col = 0;
    if (pos_sub >= rx) pos_sub = 0;
    if (pos_row >= ry) pos_row = 0;
    if (pos_row == 0 && pos_sub == 0) begin
      col_cnt[pos_col] = 0;
      for (int ch = 0; ch < MaxChannels; ch++) begin
        col_sum[pos_col][ch] = 0;
        col_first[pos_col][ch] = sample_of(p, ch);
      end
    end
    if (reg_mask_en == 0 || p.pixel_valid) begin
      col_cnt[pos_col]++;
      for (int ch = 0; ch < nc; ch++) col_sum[pos_col][ch] += sample_of(p, ch);
    end
    if (pos_row == ry - 1 && pos_sub == rx - 1) begin
      cnt = col_cnt[pos_col];
      for (int ch = 0; ch < MaxChannels; ch++) begin
        v = 0;
        if (ch < nc) v = (cnt != 0) ? col_sum[pos_col][ch] / cnt : col_first[pos_col][ch];
        avg[ch] = v[SampleBits-1:0];
      end
      res.avg_0 = avg[0];
      res.avg_1 = avg[1];
      res.avg_2 = avg[2];
      res.avg_3 = avg[3];
      res.used_fallback = (cnt == 0);
      res.line_end = (pos_col == ow - 1);
      pending_pixels.push_back(res);
    end
    pos_sub++;
    if (pos_sub >= rx) begin
      pos_sub = 0;
      pos_col++;
      if (pos_col >= ow) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= ry) pos_row = 0;
      end
    end
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected output pixel", 32'(out_data), 0);
      end else begin
        pix_out_t want;
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (want.used_fallback) fallbacks_seen++;
        if (out_data.avg_0 !== want.avg_0) report_mismatch("avg_0", out_data.avg_0, want.avg_0);
        if (out_data.avg_1 !== want.avg_1) report_mismatch("avg_1", out_data.avg_1, want.avg_1);
        if (out_data.avg_2 !== want.avg_2) report_mismatch("avg_2", out_data.avg_2, want.avg_2);
        if (out_data.avg_3 !== want.avg_3) report_mismatch("avg_3", out_data.avg_3, want.avg_3);
        if (out_data.used_fallback !== want.used_fallback) begin
          report_mismatch("used_fallback", out_data.used_fallback, want.used_fallback);
        end
        if (out_data.line_end !== want.line_end) begin
          report_mismatch("line_end", out_data.line_end, want.line_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_stretch || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_pixel(pix_in_t p);
    if (!quiet_stretch && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    decimate_pixel(p);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned rx, int unsigned ry, int unsigned ow,
                              int unsigned nc, int unsigned men);
    write_register(RegRatioX, CfgDataBits'(rx));
    write_register(RegRatioY, CfgDataBits'(ry));
    write_register(RegOutWidth, CfgDataBits'(ow));
    write_register(RegChannels, CfgDataBits'(nc));
    write_register(RegMaskEn, CfgDataBits'(men));
  endtask

  function automatic pix_in_t random_pixel(int unsigned valid_pct);
    pix_in_t p;
    p = {$urandom, $urandom, 1'b0};
    if ($urandom_range(9) == 0) p.sample_0 = '1;
    if ($urandom_range(9) == 0) p.sample_1 = '0;
    p.pixel_valid = ($urandom_range(99) < valid_pct);
    return p;
  endfunction

  function automatic pix_in_t flat_pixel(logic [SampleBits-1:0] s, logic v);
    pix_in_t p;
    p.sample_0 = s;
    p.sample_1 = s;
    p.sample_2 = s;
    p.sample_3 = s;
    p.pixel_valid = v;
    return p;
  endfunction

  task automatic test_reset_defaults();
    send_pixel(flat_pixel('0, 1'b0));
    send_pixel(flat_pixel('1, 1'b1));
    send_pixel(random_pixel(50));
    send_pixel(random_pixel(50));
  endtask

  task automatic test_masked_blocks();
    set_geometry(2, 2, 2, 4, 1);
    send_pixel(flat_pixel('1, 1'b1));
    send_pixel(flat_pixel('1, 1'b1));
    send_pixel(flat_pixel(16'h1234, 1'b0));
    send_pixel(flat_pixel(16'h0001, 1'b0));
    send_pixel(flat_pixel('1, 1'b1));
    send_pixel(flat_pixel(16'h0002, 1'b0));
    send_pixel(flat_pixel(16'h5555, 1'b0));
    send_pixel(flat_pixel(16'h0003, 1'b0));
    for (int i = 0; i < 8; i++) send_pixel(random_pixel(50));
    write_register(RegMaskEn, '0);
    for (int i = 0; i < 8; i++) send_pixel(random_pixel(0));
  endtask

  task automatic test_largest_block();
    set_geometry(MaxRatio, MaxRatio, 1, 4, 0);
    for (int i = 0; i < MaxRatio * MaxRatio; i++) send_pixel(flat_pixel('1, 1'b0));
  endtask

  task automatic test_widest_line();
    set_geometry(1, 1, MaxOutWidth, 2, 1);
    for (int i = 0; i < 16; i++) send_pixel(random_pixel(70));
  endtask

  task automatic test_register_edges();
    set_geometry(0, 5'h1f, 0, 0, 1);
    for (int i = 0; i < 40; i++) send_pixel(random_pixel(40));
    set_geometry(11'h7e3, 11'h7e0, 11'h7ff, 7, 0);
    for (int i = 0; i < 12; i++) send_pixel(random_pixel(40));
    set_geometry(2, 1, 3, 5, 1);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel(50));
    for (int idx = RegMaskEn + 1; idx < (1 << CfgIdxBits); idx++) begin
      write_register(CfgIdxBits'(idx), CfgDataBits'($urandom));
    end
    for (int i = 0; i < 9; i++) send_pixel(random_pixel(50));
  endtask

  task automatic test_output_stall();
    set_geometry(1, 1, 4, 4, 0);
    quiet_stretch = 1'b1;
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(50));
    quiet_stretch = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned budget, count, valid_pct;
    budget = 40;
    while (budget != 0) begin
      if ($urandom_range(7) == 0) begin
        set_geometry($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        set_geometry($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(8, 1),
                     $urandom_range(4, 1), $urandom_range(1));
      end
      valid_pct = $urandom_range(2) * 50;
      quiet_stretch = ($urandom_range(5) == 0);
      count = clamp($urandom_range(30, 10), 1, budget);
      for (int i = 0; i < count; i++) send_pixel(random_pixel(valid_pct));
      budget -= count;
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    errors = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    fallbacks_seen = 0;
    quiet_stretch = 1'b0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_ratio_x = 1;
    reg_ratio_y = 1;
    reg_out_width = 1;
    reg_channels = 1;
    reg_mask_en = 0;
    pos_col = 0;
    pos_sub = 0;
    pos_row = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_masked_blocks();
    test_largest_block();
    test_widest_line();
    test_register_edges();
    test_output_stall();
    test_random_frames();
    wait_drained();
    $display("Sent %0d source pixels and checked %0d output pixels, %0d of them fallbacks,",
             pixels_sent, pixels_checked, fallbacks_seen);
    $display("over masked and unmasked blocks, edge geometries and output stalls.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d output pixels outstanding.", pending_pixels.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/mbd_pkg.sv
rtl/masked_box_decimator_core.sv
tb/tb.sv
